// File: rtl/core/adti_pkg.sv
package adti_pkg;

   localparam int StartWidth = 57;
   localparam int BytesWidth = 25;
   localparam int SsecWidth  = 48;
   localparam int SumWidth   = 26;
   localparam int CountWidth = 17;
   localparam int MaxSteps   = 10;

   localparam logic [1:0] STATUS_WRITE     = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_RANGE     = 2'd2;
   localparam logic [1:0] STATUS_TOO_MANY  = 2'd3;

   localparam logic [2:0] OFF_COUNT  = 3'd2;
   localparam logic [2:0] OFF_LBA_LO = 3'd3;
   localparam logic [2:0] OFF_LBA_MD = 3'd4;
   localparam logic [2:0] OFF_LBA_HI = 3'd5;
   localparam logic [2:0] OFF_SELECT = 3'd6;
   localparam logic [2:0] OFF_CMD    = 3'd7;

   localparam logic [7:0] SEL_LBA    = 8'h40;
   localparam logic [7:0] CMD_RD     = 8'hC8;
   localparam logic [7:0] CMD_WR     = 8'hCA;
   localparam logic [7:0] CMD_RD_EXT = 8'h25;
   localparam logic [7:0] CMD_WR_EXT = 8'h35;

   localparam logic [CountWidth-1:0] MAXSEC28 = CountWidth'(255);
   localparam logic [CountWidth-1:0] MAXSEC48 = CountWidth'(65535);

   localparam logic [0:0] CSR_SECTOR_LOG2 = 1'b0;
   localparam logic [0:0] CSR_LBA48_MASK  = 1'b1;

   typedef struct packed {
      logic [StartWidth-1:0] start_byte;
      logic [BytesWidth-1:0] byte_count;
      logic                  is_write;
      logic [1:0]            drive;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       secondary;
      logic [2:0] reg_offset;
      logic [7:0] reg_value;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                  status;
      logic                        secondary;
      logic [3:0]                  num_steps;
      logic [MaxSteps-1:0][2:0]    reg_offsets;
      logic [MaxSteps-1:0][7:0]    reg_values;
   } plan_type;

endpackage

// File: rtl/core/adti_plan.sv
module adti_plan (
   input  adti_pkg::req_type  req,
   input  logic [3:0]         sector_size_log2,
   input  logic [3:0]         lba48_drive_mask,
   output adti_pkg::plan_type plan
);

   logic [1:0]                        sh_code;
   logic                              lba48;
   logic [adti_pkg::SsecWidth-1:0]    ssec;
   logic [11:0]                       mask;
   logic [adti_pkg::SumWidth-1:0]     sum;
   logic [adti_pkg::CountWidth-1:0]   count;
   logic [adti_pkg::SsecWidth:0]      total;
   logic [adti_pkg::SsecWidth:0]      limit;
   logic                              too_many;
   logic [7:0]                        sel;
   logic [7:0]                        cmd;

   always_comb begin
      if (sector_size_log2 < 4'd9) begin
         sh_code = 2'd0;
      end else if (sector_size_log2 > 4'd12) begin
         sh_code = 2'd3;
      end else begin
         sh_code = 2'(sector_size_log2 - 4'd9);
      end
   end

   assign lba48 = lba48_drive_mask[req.drive];

   always_comb begin
      case (sh_code)
         2'd0: begin
            ssec  = req.start_byte[56:9];
            mask  = 12'h1FF;
         end
         2'd1: begin
            ssec  = {1'b0, req.start_byte[56:10]};
            mask  = 12'h3FF;
         end
         2'd2: begin
            ssec  = {2'b0, req.start_byte[56:11]};
            mask  = 12'h7FF;
         end
         default: begin
            ssec  = {3'b0, req.start_byte[56:12]};
            mask  = 12'hFFF;
         end
      endcase
   end

   assign sum = {1'b0, req.byte_count}
              + adti_pkg::SumWidth'(req.start_byte[11:0] & mask)
              + adti_pkg::SumWidth'(mask);

   always_comb begin
      case (sh_code)
         2'd0:    count = adti_pkg::CountWidth'(sum[25:9]);
         2'd1:    count = adti_pkg::CountWidth'(sum[25:10]);
         2'd2:    count = adti_pkg::CountWidth'(sum[25:11]);
         default: count = adti_pkg::CountWidth'(sum[25:12]);
      endcase
   end

   assign total = {1'b0, ssec} + (adti_pkg::SsecWidth + 1)'(count);
   assign limit = lba48 ? ((adti_pkg::SsecWidth + 1)'(1) << 48)
                        : ((adti_pkg::SsecWidth + 1)'(1) << 28);
   assign too_many = lba48 ? (count > adti_pkg::MAXSEC48) : (count > adti_pkg::MAXSEC28);

   assign sel = adti_pkg::SEL_LBA | {3'b0, req.drive[0], 4'b0}
              | (lba48 ? 8'h00 : {4'b0, ssec[27:24]});
   assign cmd = lba48 ? (req.is_write ? adti_pkg::CMD_WR_EXT : adti_pkg::CMD_RD_EXT)
                      : (req.is_write ? adti_pkg::CMD_WR : adti_pkg::CMD_RD);

   always_comb begin
      plan.status      = adti_pkg::STATUS_WRITE;
      plan.secondary   = 1'b0;
      plan.num_steps   = 4'd1;
      plan.reg_offsets = '0;
      plan.reg_values  = '0;
      if (req.byte_count == '0) begin
         plan.status = adti_pkg::STATUS_EMPTY;
      end else if (total > limit) begin
         plan.status = adti_pkg::STATUS_RANGE;
      end else if (too_many) begin
         plan.status = adti_pkg::STATUS_TOO_MANY;
      end else begin
         plan.secondary      = req.drive[1];
         plan.reg_offsets[0] = adti_pkg::OFF_SELECT;
         plan.reg_values[0]  = sel;
         if (lba48) begin
            plan.num_steps      = 4'd10;
            plan.reg_offsets[1] = adti_pkg::OFF_COUNT;
            plan.reg_values[1]  = count[15:8];
            plan.reg_offsets[2] = adti_pkg::OFF_LBA_LO;
            plan.reg_values[2]  = ssec[31:24];
            plan.reg_offsets[3] = adti_pkg::OFF_LBA_MD;
            plan.reg_values[3]  = ssec[39:32];
            plan.reg_offsets[4] = adti_pkg::OFF_LBA_HI;
            plan.reg_values[4]  = ssec[47:40];
            plan.reg_offsets[5] = adti_pkg::OFF_COUNT;
            plan.reg_values[5]  = count[7:0];
            plan.reg_offsets[6] = adti_pkg::OFF_LBA_LO;
            plan.reg_values[6]  = ssec[7:0];
            plan.reg_offsets[7] = adti_pkg::OFF_LBA_MD;
            plan.reg_values[7]  = ssec[15:8];
            plan.reg_offsets[8] = adti_pkg::OFF_LBA_HI;
            plan.reg_values[8]  = ssec[23:16];
            plan.reg_offsets[9] = adti_pkg::OFF_CMD;
            plan.reg_values[9]  = cmd;
         end else begin
            plan.num_steps      = 4'd6;
            plan.reg_offsets[1] = adti_pkg::OFF_COUNT;
            plan.reg_values[1]  = count[7:0];
            plan.reg_offsets[2] = adti_pkg::OFF_LBA_LO;
            plan.reg_values[2]  = ssec[7:0];
            plan.reg_offsets[3] = adti_pkg::OFF_LBA_MD;
            plan.reg_values[3]  = ssec[15:8];
            plan.reg_offsets[4] = adti_pkg::OFF_LBA_HI;
            plan.reg_values[4]  = ssec[23:16];
            plan.reg_offsets[5] = adti_pkg::OFF_CMD;
            plan.reg_values[5]  = cmd;
         end
      end
   end

endmodule

// File: rtl/core/ata_dma_taskfile_issuer.sv
// a request crosses the input, command and output registers to its first result
// throughput: one result per cycle while rsp_stall is low; a request gives 6 writes
// (28-bit), 10 (48-bit) or a single status result, after those of the previous request
// the input register and the command register let the next request be planned
// while the current one is still being issued
// reset: synchronous; clears all valid flags, sector size log2 to 9, 48-bit mask to 0
module ata_dma_taskfile_issuer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  adti_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output adti_pkg::rsp_type   rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [0:0]          csr_index,
   input  logic [3:0]          csr_data
);

   logic [3:0]          sector_log2_ff;
   logic [3:0]          lba48_mask_ff;

   logic                in_valid_ff;
   adti_pkg::req_type   in_req_ff;

   logic                plan_valid_ff;
   adti_pkg::plan_type  plan_ff;
   adti_pkg::plan_type  plan_in;
   logic [3:0]          idx_ff;

   logic                rsp_valid_ff;
   adti_pkg::rsp_type   rsp_data_ff;
   adti_pkg::rsp_type   rsp_data_in;

   logic                rsp_load;
   logic                step_last;
   logic                plan_free;
   logic                in_move;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_log2_ff <= 4'd9;
         lba48_mask_ff  <= 4'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            adti_pkg::CSR_SECTOR_LOG2: sector_log2_ff <= csr_data;
            adti_pkg::CSR_LBA48_MASK:  lba48_mask_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   adti_plan u_plan (
      .req              (in_req_ff),
      .sector_size_log2 (sector_log2_ff),
      .lba48_drive_mask (lba48_mask_ff),
      .plan             (plan_in)
   );

   assign rsp_load  = plan_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign step_last = (idx_ff == plan_ff.num_steps - 4'd1);
   assign plan_free = !plan_valid_ff || (rsp_load && step_last);
   assign in_move   = in_valid_ff && plan_free;
   assign req_stall = in_valid_ff && !plan_free;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_req_ff <= req_data;
      end
   end

   // command register and write sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         plan_valid_ff <= 1'b0;
         idx_ff        <= 4'd0;
      end else begin
         if (plan_free) begin
            plan_valid_ff <= in_move;
            idx_ff        <= 4'd0;
         end else if (rsp_load) begin
            idx_ff <= idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_move) begin
         plan_ff <= plan_in;
      end
   end

   always_comb begin
      rsp_data_in.status     = plan_ff.status;
      rsp_data_in.secondary  = plan_ff.secondary;
      rsp_data_in.reg_offset = plan_ff.reg_offsets[idx_ff];
      rsp_data_in.reg_value  = plan_ff.reg_values[idx_ff];
      rsp_data_in.last       = step_last;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= plan_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
